FILE: rtl/drle_pkg.sv
package drle_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam logic [7:0] ASCII_ZERO = 8'h30;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIGIT,
        ST_CHAR
    } drle_state_t;

    // decimal digits needed for the largest count 2^bits - 1
    function automatic int count_digits(input int bits);
        longint v;
        int     n;
        v = (longint'(1) << bits) - 1;
        n = 0;
        for (int i = 0; i < 12; i++) begin
            if (v != 0) begin
                v = v / 10;
                n = n + 1;
            end
        end
        if (n == 0) begin
            n = 1;
        end
        return n;
    endfunction

endpackage

FILE: rtl/decimal_run_length_encoder_core.sv
// decimal run-length encoder
// s_ channel: one character per word, s_tdata = character, s_tlast marks the
// final character of a message. m_ channel: one output byte per word,
// m_tdata = ASCII count digit or run character, m_tlast = end of message,
// m_tuser = {last result of the input word, run split, run character}.
// A character that extends the open run is taken and gives no
// output. A character that closes a run (different character, end of message
// or a run at the maximum count) makes the block emit the count in decimal,
// most significant digit first without leading zeros, then the run character.
// The count is kept as a packed BCD counter next to the binary count, and the
// digits leave through a shift register one digit per cycle unless stalled, so
// a run of d digits closes with d digit words and the run character (then a 1
// and the new character if the closing word also ends the message). m_tvalid
// rises once the output register takes the first digit. s_tready is high
// whenever no run is being emitted, also while the final result still waits in
// the output register. A stalled receiver holds the output register and freezes
// the emission. Reset clears the open run and drops m_tvalid.
module decimal_run_length_encoder_core #(
    parameter int COUNT_BITS = drle_pkg::COUNT_BITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte
    input  logic       s_tlast,   // in_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic       m_tlast,   // end_of_message
    output logic [2:0] m_tuser    // is_run_char, run_split, last_of_item
);
    import drle_pkg::*;

    localparam int NUM_DIGITS = count_digits(COUNT_BITS);
    localparam int DW         = NUM_DIGITS * 4;
    localparam int DCW        = $clog2(NUM_DIGITS + 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
    localparam logic [DW-1:0] BCD_ONE     = DW'(1);
    localparam logic [DW-1:0] BCD_ONE_ALN = {4'd1, {(DW - 4){1'b0}}};

    drle_state_t state_reg, state_next;

    logic                  run_active_reg, run_active_next;
    logic [7:0]            run_byte_reg, run_byte_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]         bcd_reg, bcd_next;

    logic [DW-1:0]  emit_bcd_reg, emit_bcd_next;
    logic [DCW-1:0] emit_cnt_reg, emit_cnt_next;
    logic [7:0]     emit_byte_reg, emit_byte_next;
    logic           emit_split_reg, emit_split_next;
    logic           emit_eom_reg, emit_eom_next;
    logic           pend_reg, pend_next;
    logic [7:0]     pend_byte_reg, pend_byte_next;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic [3:0] out_flags_reg, out_flags_next;  // run char, split, eom, last of item

    logic           accept;
    logic           out_load;
    logic           same_byte;
    logic [DW-1:0]  bcd_inc;
    logic           carry;
    logic [DW-1:0]  src_bcd;
    logic [DW-1:0]  src_aln;
    logic [DCW-1:0] src_nd;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_load  = (state_reg != ST_IDLE) && (!out_valid_reg || m_tready);
    assign same_byte = (s_tdata == run_byte_reg);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_flags_reg[2];
    assign m_tuser  = {out_flags_reg[3], out_flags_reg[1], out_flags_reg[0]};

    // decimal increment of the bcd count, ripple over the digits
    always_comb begin
        bcd_inc = bcd_reg;
        carry   = 1'b1;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (carry) begin
                if (bcd_reg[i*4 +: 4] == 4'd9) begin
                    bcd_inc[i*4 +: 4] = 4'd0;
                end else begin
                    bcd_inc[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd1;
                    carry = 1'b0;
                end
            end
        end
    end

    // count to emit, pushed up so the leading nonzero digit sits on top
    always_comb begin
        if (!run_active_reg) begin
            src_bcd = BCD_ONE;
        end else if (same_byte && (cnt_reg != CNT_MAX)) begin
            src_bcd = bcd_inc;
        end else begin
            src_bcd = bcd_reg;
        end
        src_aln = src_bcd;
        src_nd  = DCW'(NUM_DIGITS);
        for (int i = 0; i < NUM_DIGITS - 1; i++) begin
            if (src_aln[DW-1 -: 4] == 4'd0) begin
                src_aln = src_aln << 4;
                src_nd  = src_nd - DCW'(1);
            end
        end
    end

    always_comb begin
        state_next      = state_reg;
        run_active_next = run_active_reg;
        run_byte_next   = run_byte_reg;
        cnt_next        = cnt_reg;
        bcd_next        = bcd_reg;
        emit_bcd_next   = emit_bcd_reg;
        emit_cnt_next   = emit_cnt_reg;
        emit_byte_next  = emit_byte_reg;
        emit_split_next = emit_split_reg;
        emit_eom_next   = emit_eom_reg;
        pend_next       = pend_reg;
        pend_byte_next  = pend_byte_reg;
        out_byte_next   = out_byte_reg;
        out_flags_next  = out_flags_reg;
        out_valid_next  = out_valid_reg && !m_tready;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    emit_bcd_next = src_aln;
                    emit_cnt_next = src_nd;
                    if (!run_active_reg || (same_byte && (cnt_reg != CNT_MAX))) begin
                        // run opens or grows, closed only at end of message
                        emit_byte_next  = s_tdata;
                        emit_split_next = 1'b0;
                        emit_eom_next   = 1'b1;
                        pend_next       = 1'b0;
                        run_active_next = 1'b1;
                        run_byte_next   = s_tdata;
                        cnt_next        = run_active_reg ? cnt_reg + CNT_ONE : CNT_ONE;
                        bcd_next        = src_bcd;
                        if (s_tlast) begin
                            state_next = ST_DIGIT;
                        end
                    end else begin
                        // close the open run, a new run of this byte starts
                        emit_byte_next  = run_byte_reg;
                        emit_split_next = same_byte;
                        emit_eom_next   = 1'b0;
                        pend_next       = s_tlast;
                        pend_byte_next  = s_tdata;
                        run_byte_next   = s_tdata;
                        cnt_next        = CNT_ONE;
                        bcd_next        = BCD_ONE;
                        state_next      = ST_DIGIT;
                    end
                    if (s_tlast) begin
                        run_active_next = 1'b0;
                        run_byte_next   = 8'd0;
                        cnt_next        = '0;
                        bcd_next        = '0;
                    end
                end
            end
            ST_DIGIT: begin
                if (out_load) begin
                    out_valid_next = 1'b1;
                    out_byte_next  = ASCII_ZERO | {4'd0, emit_bcd_reg[DW-1 -: 4]};
                    out_flags_next = {1'b0, 1'b0, emit_split_reg, 1'b0};
                    emit_bcd_next  = emit_bcd_reg << 4;
                    emit_cnt_next  = emit_cnt_reg - DCW'(1);
                    if (emit_cnt_reg == DCW'(1)) begin
                        state_next = ST_CHAR;
                    end
                end
            end
            ST_CHAR: begin
                if (out_load) begin
                    out_valid_next = 1'b1;
                    out_byte_next  = emit_byte_reg;
                    out_flags_next = {!pend_reg, emit_eom_reg, emit_split_reg, 1'b1};
                    if (pend_reg) begin
                        // end of message right after a close: run of one
                        pend_next       = 1'b0;
                        emit_bcd_next   = BCD_ONE_ALN;
                        emit_cnt_next   = DCW'(1);
                        emit_byte_next  = pend_byte_reg;
                        emit_split_next = 1'b0;
                        emit_eom_next   = 1'b1;
                        state_next      = ST_DIGIT;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            run_active_reg <= 1'b0;
            run_byte_reg   <= 8'd0;
            cnt_reg        <= '0;
            bcd_reg        <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            run_active_reg <= run_active_next;
            run_byte_reg   <= run_byte_next;
            cnt_reg        <= cnt_next;
            bcd_reg        <= bcd_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        emit_bcd_reg   <= emit_bcd_next;
        emit_cnt_reg   <= emit_cnt_next;
        emit_byte_reg  <= emit_byte_next;
        emit_split_reg <= emit_split_next;
        emit_eom_reg   <= emit_eom_next;
        pend_byte_reg  <= pend_byte_next;
        out_byte_reg   <= out_byte_next;
        out_flags_reg  <= out_flags_next;
    end

endmodule

FILE: rtl/drle_checker.sv
module drle_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [2:0] m_tuser
);

    // a held word keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    // end of message only on the run character, which ends the input word
    a_eom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[0] && m_tuser[2])
        else $error("end of message on a digit or mid-word");

    // count words are ascii digits
    a_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> (m_tdata >= 8'h30) && (m_tdata <= 8'h39))
        else $error("count word is not a decimal digit");

    // a message end always starts an emission
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input still taken after end of message");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind decimal_run_length_encoder_core drle_checker u_drle_checker (.*);

FILE: test/decimal_run_length_encoder_core_test.sv
module decimal_run_length_encoder_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COUNT_BITS = drle_pkg::COUNT_BITS_DEF;
    localparam int unsigned COUNT_MAX = (32'd1 << COUNT_BITS) - 1;
    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int DRAIN_CYCLES = 24;
    localparam int RANDOM_ITEMS = 160;

    typedef struct packed {
        logic [7:0] ch;
        logic       run_char;
        logic       split;
        logic       eom;
        logic       last_of_item;
    } code_word_t;

    logic       aclk;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;   // in_byte
    logic       s_tlast = 1'b0;    // in_last
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // out_byte
    logic       m_tlast;           // end_of_message
    logic [2:0] m_tuser;           // is_run_char, run_split, last_of_item

    // open run as the encoder should see it
    logic [7:0]  open_char = 8'h00;
    int unsigned open_count = 0;
    logic        open_active = 1'b0;

    code_word_t pending_code[$];
    int mismatch_count = 0;
    int cycle_count = 0;

    int burst_left = 0;
    bit steady_send = 1'b0;
    int hold_request = 0;
    int hold_left = 0;
    int stall_mode = 0;
    int stall_phase = 0;

    decimal_run_length_encoder_core #(
        .COUNT_BITS(COUNT_BITS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .m_tuser(m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("[decimal_run_length_encoder_core] ERROR");
        $finish;
    end

    // decimal count digits, most significant first, then the run character
    function automatic void flush_run(input logic split, input logic eom);
        logic [7:0]  digs[12];
        int unsigned v;
        int          nd;
        code_word_t  w;
        v = open_count;
        nd = 0;
        do begin
            digs[nd] = drle_pkg::ASCII_ZERO + 8'(v % 10);
            nd++;
            v = v / 10;
        end while (v != 0);
        for (int i = nd - 1; i >= 0; i--) begin
            w.ch = digs[i];
            w.run_char = 1'b0;
            w.split = split;
            w.eom = 1'b0;
            w.last_of_item = 1'b0;
            pending_code.push_back(w);
        end
        w.ch = open_char;
        w.run_char = 1'b1;
        w.split = split;
        w.eom = eom;
        w.last_of_item = 1'b0;
        pending_code.push_back(w);
    endfunction

    function automatic void encode_char(input logic [7:0] c, input logic last);
        int         queued;
        code_word_t w;
        queued = pending_code.size();
        if (!open_active) begin
            open_char = c;
            open_count = 1;
            open_active = 1'b1;
        end else if (c == open_char) begin
            if (open_count >= COUNT_MAX) begin
                flush_run(1'b1, 1'b0);
                open_count = 1;
            end else begin
                open_count = open_count + 1;
            end
        end else begin
            flush_run(1'b0, 1'b0);
            open_char = c;
            open_count = 1;
        end
        if (last) begin
            flush_run(1'b0, 1'b1);
            open_char = 8'h00;
            open_count = 0;
            open_active = 1'b0;
        end
        if (pending_code.size() > queued) begin
            w = pending_code.pop_back();
            w.last_of_item = 1'b1;
            pending_code.push_back(w);
        end
    endfunction

    function automatic void check_word();
        code_word_t got;
        code_word_t want;
        got.ch = m_tdata;
        got.run_char = m_tuser[0];
        got.split = m_tuser[1];
        got.eom = m_tlast;
        got.last_of_item = m_tuser[2];
        if (pending_code.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected word: byte=%h char=%b split=%b eom=%b last=%b",
                         got.ch, got.run_char, got.split, got.eom, got.last_of_item);
        end else begin
            want = pending_code.pop_front();
            if (got !== want) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $write("mismatch exp/act: byte=%h/%h char=%b/%b ",
                           want.ch, got.ch, want.run_char, got.run_char);
                    $display("split=%b/%b eom=%b/%b last=%b/%b",
                             want.split, got.split, want.eom, got.eom,
                             want.last_of_item, got.last_of_item);
                end
            end
        end
    endfunction

    // inputs first so an accepted word always has its expectations queued
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                encode_char(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                check_word();
        end
    end

    // receiver: long hold-off on request, otherwise changing stall patterns
    always @(negedge aclk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (stall_phase == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_phase = $urandom_range(16, 96);
            end
            stall_phase--;
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= (stall_phase % 4) != 0;
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (!steady_send && $urandom_range(0, 2) != 0)
                gap = $urandom_range(1, 6);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tlast <= last;
        do
            @(posedge aclk);
        while (!(s_tvalid && s_tready));
        @(negedge aclk);
        burst_left--;
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_code.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic send_run(input logic [7:0] c, input int len, input logic last);
        for (int i = 0; i < len; i++)
            send_char(c, last && (i == len - 1));
    endtask

    function automatic logic [7:0] other_char(input logic [7:0] prev);
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        if (c == prev)
            c = (c == 8'hff) ? 8'h01 : c + 8'h01;
        return c;
    endfunction

    task automatic test_directed();
        send_char(8'h01, 1'b1);              // single character message
        send_run(8'hff, 2, 1'b0);
        send_run(8'h00, 3, 1'b0);            // zero character forms a run too
        send_char(8'h41, 1'b1);              // new character that also ends it
        send_run(8'h78, 10, 1'b0);           // first two-digit count
        send_char(8'h79, 1'b1);
        send_run(8'h6b, 2, 1'b1);            // last word extends the open run
        send_run(8'h80, 1, 1'b0);
        send_char(8'h7f, 1'b1);
        wait_for_drain();
    endtask

    task automatic test_long_runs();
        steady_send = 1'b1;
        send_run(8'h6d, 999, 1'b0);
        send_run(8'h6e, 1000, 1'b1);
        send_run(8'h65, 9999, 1'b0);
        send_run(8'h66, 10000, 1'b1);
        // run at the maximum count is split by one more equal character
        send_run(8'h5a, COUNT_MAX, 1'b0);
        send_char(8'h5a, 1'b0);
        send_char(8'h5a, 1'b0);
        send_char(8'h5a, 1'b1);
        send_run(8'h71, COUNT_MAX, 1'b0);
        send_char(8'h72, 1'b1);
        steady_send = 1'b0;
        wait_for_drain();
    endtask

    task automatic test_receiver_hold();
        logic [7:0] c;
        c = 8'h00;
        hold_request = 400;
        steady_send = 1'b1;
        for (int i = 0; i < 20; i++) begin
            c = other_char(c);
            send_char(c, ($urandom_range(0, 4) == 0) || (i == 19));
        end
        steady_send = 1'b0;
        wait_for_drain();
    endtask

    task automatic test_sender_pause();
        send_run(8'h33, 12, 1'b0);
        wait_for_drain();
        // the open run survives the idle stretch
        send_run(8'h33, 3, 1'b0);
        send_char(8'h34, 1'b1);
        wait_for_drain();
    endtask

    task automatic test_random_messages();
        int         counted;
        int         runs;
        int         len;
        int         k;
        logic [7:0] c;
        logic [7:0] prev;
        counted = 0;
        prev = 8'h00;
        while (counted < RANDOM_ITEMS) begin
            runs = $urandom_range(1, 6);
            for (int r = 0; r < runs; r++) begin
                c = ($urandom_range(0, 9) == 0) ? prev : other_char(prev);
                k = $urandom_range(0, 99);
                if (k < 72)
                    len = $urandom_range(1, 3);
                else if (k < 95)
                    len = $urandom_range(4, 12);
                else
                    len = $urandom_range(95, 105);
                send_run(c, len, r == runs - 1);
                prev = c;
                counted += len;
            end
            if ($urandom_range(0, 7) == 0)
                wait_for_drain();
        end
        wait_for_drain();
    endtask

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_receiver_hold();
        test_sender_pause();
        test_long_runs();
        test_random_messages();
        if (pending_code.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0) begin
            $display("[decimal_run_length_encoder_core] OK");
        end else begin
            $display("[decimal_run_length_encoder_core] ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/drle_pkg.sv
rtl/decimal_run_length_encoder_core.sv
rtl/drle_checker.sv
test/decimal_run_length_encoder_core_test.sv
